[hdl/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon tester.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

    localparam int FIELD_W     = 32;
    localparam int KIND_W      = 2;
    localparam int NUM_CORNERS = 4;
    localparam int CORNER_W    = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_POINT = 2'd1,
        KIND_RECT  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_DAT,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic hit;
        logic odd;
    } t_edge_stat;

endpackage

`default_nettype wire

[hdl/pip_if.sv]
// ----------------------------------------------------------------------------
// pip_if
// Valid/ready channels of the point-in-polygon tester: command and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_in_if;
    import pip_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic                      first;
    logic signed [FIELD_W-1:0] x0;
    logic signed [FIELD_W-1:0] y0;
    logic signed [FIELD_W-1:0] x1;
    logic signed [FIELD_W-1:0] y1;
    logic signed [FIELD_W-1:0] x2;
    logic signed [FIELD_W-1:0] y2;
    logic signed [FIELD_W-1:0] x3;
    logic signed [FIELD_W-1:0] y3;

    modport source (output valid, kind, first, x0, y0, x1, y1, x2, y2, x3, y3,
                    input ready);
    modport sink (input valid, kind, first, x0, y0, x1, y1, x2, y2, x3, y3,
                  output ready);
endinterface

interface pip_out_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, inside_res, input ready);
    modport sink (input valid, inside_res, output ready);
endinterface

`default_nettype wire

[hdl/pip_vstore.sv]
// ----------------------------------------------------------------------------
// pip_vstore
// Vertex store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_vstore #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/pip_edge.sv]
// ----------------------------------------------------------------------------
// pip_edge
// Edge test pipeline: boundary hit and ray crossing of each issued edge,
// with one shared multiplier (issues may not overlap in its use) and hit/parity accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge #(
    parameter int CW = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clr,
    input  logic                i_issue,
    input  logic signed [CW-1:0] i_ax,
    input  logic signed [CW-1:0] i_ay,
    input  logic signed [CW-1:0] i_bx,
    input  logic signed [CW-1:0] i_by,
    input  logic signed [CW-1:0] i_px,
    input  logic signed [CW-1:0] i_py,
    output pip_pkg::t_edge_stat  o_stat
);
    import pip_pkg::*;

    localparam int PW = 2 * CW + 2;

    logic signed [CW:0]   r_dx_ba;
    logic signed [CW:0]   r_dy_pa;
    logic signed [CW:0]   r_dx_pa;
    logic signed [CW:0]   r_dy_ba;
    logic                 r_box_a;
    logic                 r_str_a;
    logic                 r_up_a;
    logic                 r_box_c;
    logic                 r_str_c;
    logic                 r_up_c;
    logic                 r_v_a;
    logic                 r_v_b;
    logic                 r_v_c;
    logic signed [PW-1:0] r_p1;
    logic signed [PW-1:0] r_p2;
    logic                 r_hit;
    logic                 r_odd;

    logic signed [CW:0]   w_mul_a;
    logic signed [CW:0]   w_mul_b;
    logic signed [PW-1:0] w_prod;
    logic                 w_box;
    logic                 w_hit;
    logic                 w_cross;

    assign w_box = ((i_px >= i_ax && i_px <= i_bx) || (i_px >= i_bx && i_px <= i_ax)) &&
                   ((i_py >= i_ay && i_py <= i_by) || (i_py >= i_by && i_py <= i_ay));

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_dx_ba <= {i_bx[CW-1], i_bx} - {i_ax[CW-1], i_ax};
            r_dy_pa <= {i_py[CW-1], i_py} - {i_ay[CW-1], i_ay};
            r_dx_pa <= {i_px[CW-1], i_px} - {i_ax[CW-1], i_ax};
            r_dy_ba <= {i_by[CW-1], i_by} - {i_ay[CW-1], i_ay};
            r_box_a <= w_box;
            r_str_a <= (i_ay > i_py) != (i_by > i_py);
            r_up_a  <= i_by > i_ay;
        end
    end

    assign w_mul_a = r_v_a ? r_dx_ba : r_dx_pa;
    assign w_mul_b = r_v_a ? r_dy_pa : r_dy_ba;
    assign w_prod  = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        if (r_v_a) begin
            r_p1 <= w_prod;
        end
        if (r_v_b) begin
            r_p2    <= w_prod;
            r_box_c <= r_box_a;
            r_str_c <= r_str_a;
            r_up_c  <= r_up_a;
        end
    end

    assign w_hit   = r_box_c && (r_p1 == r_p2);
    assign w_cross = r_str_c && (r_up_c ? (r_p2 < r_p1) : (r_p2 > r_p1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
            r_hit <= 1'b0;
            r_odd <= 1'b0;
        end else begin
            r_v_a <= i_issue;
            r_v_b <= r_v_a;
            r_v_c <= r_v_b;
            if (i_clr) begin
                r_hit <= 1'b0;
                r_odd <= 1'b0;
            end else if (r_v_c) begin
                r_hit <= r_hit | w_hit;
                r_odd <= r_odd ^ w_cross;
            end
        end
    end

    assign o_stat.busy = r_v_a | r_v_b | r_v_c;
    assign o_stat.hit  = r_hit;
    assign o_stat.odd  = r_odd;

endmodule

`default_nettype wire

[hdl/point_in_polygon_test.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Ray-casting point and rectangle containment test over a stored polygon.
//
// Items arrive on i_in (valid/ready). A load item (kind 0) writes one vertex;
// first = 1 restarts the polygon, loads past MAX_VERTICES are
// dropped. A point query (kind 1) or rectangle query (kind 2) returns one
// item on o_out: inside_res = 1 when the point, or all four corners, lie
// inside the polygon or on its boundary. An empty polygon answers 0.
// An empty polygon answers without reading the vertex store. Each edge
// passes through the S_RD and S_DAT states in turn, one edge at a time,
// paced by the single vertex store read port and the shared edge multiplier.
// One query is worked on at a time; i_in.ready is low while it runs.
// A finished result waits in the output register while o_out.ready is low;
// loads are still taken, and a following query holds in its last state with
// i_in.ready low until that register is free.
// Reset empties the polygon and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_WIDTH  = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pip_in_if.sink    i_in,
    pip_out_if.source o_out
);
    import pip_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_step;
    logic [CORNER_W-1:0]   r_corner;
    logic                  r_rect;
    logic                  r_all;
    logic signed [CW-1:0]  r_px [NUM_CORNERS];
    logic signed [CW-1:0]  r_py [NUM_CORNERS];
    logic signed [CW-1:0]  r_ax;
    logic signed [CW-1:0]  r_ay;
    logic                  r_out_valid;
    logic                  r_out_res;

    logic                  w_accept;
    logic                  w_start;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic                  w_rd_en;
    logic [AW-1:0]         w_raddr;
    logic [2*CW-1:0]       w_rdata;
    logic                  w_issue;
    logic                  w_clr;
    logic                  w_next_corner;
    logic                  w_load_out;
    logic signed [CW-1:0]  w_bx;
    logic signed [CW-1:0]  w_by;
    t_edge_stat            w_stat;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid & i_in.ready;
    assign w_start    = w_accept && (i_in.kind inside {KIND_POINT, KIND_RECT});

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[AW-1:0];
        if (w_accept && i_in.kind == KIND_LOAD) begin
            if (i_in.first) begin
                w_we    = 1'b1;
                w_waddr = '0;
            end else if (r_count < MAX_CNT) begin
                w_we = 1'b1;
            end
        end
    end

    assign w_raddr = (r_step == r_count) ? '0 : r_step[AW-1:0];
    assign w_bx    = w_rdata[CW-1:0];
    assign w_by    = w_rdata[2*CW-1:CW];

    always_comb begin
        n_state       = r_state;
        w_rd_en       = 1'b0;
        w_issue       = 1'b0;
        w_clr         = 1'b0;
        w_next_corner = 1'b0;
        w_load_out    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    w_clr   = 1'b1;
                    n_state = (r_count == '0) ? S_DONE : S_RD;
                end
            end
            S_RD: begin
                w_rd_en = 1'b1;
                n_state = S_DAT;
            end
            S_DAT: begin
                w_issue = (r_step != '0);
                n_state = (r_step == r_count) ? S_DRAIN : S_RD;
            end
            S_DRAIN: begin
                if (!w_stat.busy) begin
                    if (!r_rect || r_corner == CORNER_W'(NUM_CORNERS - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        w_clr         = 1'b1;
                        w_next_corner = 1'b1;
                        n_state       = S_RD;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_step      <= '0;
            r_corner    <= '0;
            r_rect      <= 1'b0;
            r_all       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_we) begin
                r_count <= i_in.first ? CNT_W'(1) : r_count + CNT_W'(1);
            end
            if (w_start) begin
                r_step   <= '0;
                r_corner <= '0;
                r_rect   <= (i_in.kind == KIND_RECT);
                r_all    <= (r_count != '0);
            end else if (r_state == S_DAT && r_step != r_count) begin
                r_step <= r_step + CNT_W'(1);
            end else if (w_next_corner) begin
                r_step   <= '0;
                r_corner <= r_corner + CORNER_W'(1);
            end
            if (r_state == S_DRAIN && !w_stat.busy) begin
                r_all <= r_all & (w_stat.hit | w_stat.odd);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_px[0] <= i_in.x0[CW-1:0];
            r_py[0] <= i_in.y0[CW-1:0];
            r_px[1] <= i_in.x1[CW-1:0];
            r_py[1] <= i_in.y1[CW-1:0];
            r_px[2] <= i_in.x2[CW-1:0];
            r_py[2] <= i_in.y2[CW-1:0];
            r_px[3] <= i_in.x3[CW-1:0];
            r_py[3] <= i_in.y3[CW-1:0];
        end
        if (r_state == S_DAT) begin
            r_ax <= w_bx;
            r_ay <= w_by;
        end
        if (w_load_out) begin
            r_out_res <= r_all;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.inside_res = r_out_res;

    pip_vstore #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (2 * CW)
    ) u_vstore (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_in.y0[CW-1:0], i_in.x0[CW-1:0]}),
        .i_re    (w_rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pip_edge #(
        .CW (CW)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_clr),
        .i_issue (w_issue),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_bx    (w_bx),
        .i_by    (w_by),
        .i_px    (r_px[r_corner]),
        .i_py    (r_py[r_corner]),
        .o_stat  (w_stat)
    );

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !w_stat.busy)
        else $error("input ready while edges are in flight");

    a_issue_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> !w_issue)
        else $error("edge issued on consecutive cycles");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("vertex count past capacity");

    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> (r_step <= r_count && r_count != '0))
        else $error("vertex read beyond polygon");

endmodule

`default_nettype wire
